>>> design/iterative_quicksort_engine_macros.svh
// Assertion macros for the iterative quicksort engine.
`ifndef ITERATIVE_QUICKSORT_ENGINE_MACROS_SVH
`define ITERATIVE_QUICKSORT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define IQS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iqs assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define IQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iqs assertion failed");
`else
`define IQS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IQS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/iqs_pkg.sv
// Shared constants, payload types and control structs for the quicksort engine.
package iqs_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int STK_W        = 2 * IDX_W;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_res;
    logic                         last_res;
  } out_res_t;

  typedef struct packed {
    logic load;        // write request value into the element store
    logic push_init;   // push the full range
    logic pop;         // read top of range stack
    logic range_load;  // take popped range into scan registers
    logic rd_pair;     // read elements at scan_low and scan_high
    logic step;        // compare and advance one scan step
    logic swap_wr;     // second half of a swap
    logic push_right;  // push range right of the pivot
    logic push_left;   // push range left of the pivot
    logic emit;        // read next sorted element out
  } iqs_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_ge2;
    logic stack_empty;
    logic scan_done;
    logic swap;
    logic right_ok;
    logic left_ok;
    logic emit_last;
  } iqs_stat_t;

endpackage

>>> design/iqs_ctrl.sv
// Controller state machine for the quicksort engine.
module iqs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_last,
  input  iqs_pkg::iqs_stat_t st,
  output iqs_pkg::iqs_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_START  = 10'b00_0000_0010,
    S_POP    = 10'b00_0000_0100,
    S_RANGE  = 10'b00_0000_1000,
    S_SCAN   = 10'b00_0001_0000,
    S_CMP    = 10'b00_0010_0000,
    S_SWAP   = 10'b00_0100_0000,
    S_PUSH_R = 10'b00_1000_0000,
    S_PUSH_L = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        if (st.cnt_zero) begin
          state_nxt = S_IDLE;
        end else if (st.cnt_ge2) begin
          cmd.push_init = 1'b1;
          state_nxt     = S_POP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_POP: begin
        if (st.stack_empty) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd.range_load = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = S_PUSH_R;
        end else begin
          cmd.rd_pair = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = st.swap ? S_SWAP : S_SCAN;
      end
      S_SWAP: begin
        cmd.swap_wr = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_PUSH_R: begin
        cmd.push_right = st.right_ok;
        state_nxt      = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.push_left = st.left_ok;
        state_nxt     = S_POP;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/iqs_datapath.sv
// Element store, range stack, scan registers and output register of the quicksort engine.
module iqs_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  iqs_pkg::in_req_t   in_req,
  input  iqs_pkg::iqs_cmd_t  cmd,
  output iqs_pkg::iqs_stat_t st,
  output logic               out_valid,
  output iqs_pkg::out_res_t  out_res
);

  localparam int IDX_W = iqs_pkg::IDX_W;
  localparam int CNT_W = iqs_pkg::CNT_W;
  localparam int DW    = iqs_pkg::DATA_WIDTH;
  localparam int STK_W = iqs_pkg::STK_W;

  logic [DW-1:0]    store_mem [iqs_pkg::MAX_ELEMENTS];
  logic [STK_W-1:0] stack_mem [iqs_pkg::MAX_ELEMENTS];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] depth_r;
  logic [IDX_W-1:0] low_r, high_r, lo_r, hi_r, emit_k_r, swap_addr_r;
  logic             fwd_r;
  logic [DW-1:0]    q_a_r, q_b_r, swap_data_r;
  logic [STK_W-1:0] stack_q_r;
  logic             out_valid_r, last_r;

  logic             st_we;
  logic [IDX_W-1:0] st_wa;
  logic [DW-1:0]    st_wd;
  logic [IDX_W-1:0] rd_addr_a;
  logic             sk_we;
  logic [STK_W-1:0] sk_wd;
  logic [CNT_W-1:0] depth_m1;
  logic [CNT_W-1:0] count_m1;
  logic             swap;

  assign depth_m1  = depth_r - CNT_W'(1);
  assign count_m1  = count_r - CNT_W'(1);
  assign rd_addr_a = cmd.emit ? emit_k_r : low_r;

  // Swap condition depends on scan direction.
  assign swap = fwd_r ? ($signed(q_a_r) >= $signed(q_b_r))
                      : ($signed(q_b_r) <  $signed(q_a_r));

  always_comb begin
    st_we = 1'b0;
    st_wa = low_r;
    st_wd = q_b_r;
    if (cmd.load) begin
      st_we = (count_r < CNT_W'(iqs_pkg::MAX_ELEMENTS));
      st_wa = count_r[IDX_W-1:0];
      st_wd = in_req.value;
    end else if (cmd.step) begin
      st_we = swap;
    end else if (cmd.swap_wr) begin
      st_we = 1'b1;
      st_wa = swap_addr_r;
      st_wd = swap_data_r;
    end
  end

  always_comb begin
    sk_we = cmd.push_init | cmd.push_right | cmd.push_left;
    if (cmd.push_init) begin
      sk_wd = {IDX_W'(0), count_m1[IDX_W-1:0]};
    end else if (cmd.push_right) begin
      sk_wd = {low_r + IDX_W'(1), hi_r};
    end else begin
      sk_wd = {lo_r, low_r - IDX_W'(1)};
    end
  end

  // Element store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_wa] <= st_wd;
    if (cmd.rd_pair || cmd.emit) q_a_r <= store_mem[rd_addr_a];
    if (cmd.rd_pair) q_b_r <= store_mem[high_r];
  end

  // Range stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (sk_we) stack_mem[depth_r[IDX_W-1:0]] <= sk_wd;
    if (cmd.pop) stack_q_r <= stack_mem[depth_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      depth_r     <= '0;
      emit_k_r    <= '0;
      low_r       <= '0;
      high_r      <= '0;
      fwd_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load && (count_r < CNT_W'(iqs_pkg::MAX_ELEMENTS))) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (sk_we) begin
        depth_r <= depth_r + CNT_W'(1);
      end else if (cmd.pop) begin
        depth_r <= depth_m1;
      end
      if (cmd.range_load) begin
        low_r  <= stack_q_r[STK_W-1:IDX_W];
        high_r <= stack_q_r[IDX_W-1:0];
        fwd_r  <= 1'b1;
      end else if (cmd.step) begin
        if (fwd_r) begin
          if (swap) begin
            low_r <= low_r + IDX_W'(1);
            fwd_r <= 1'b0;
          end else begin
            high_r <= high_r - IDX_W'(1);
          end
        end else begin
          if (swap) begin
            high_r <= high_r - IDX_W'(1);
            fwd_r  <= 1'b1;
          end else begin
            low_r <= low_r + IDX_W'(1);
          end
        end
      end
      if (cmd.emit) begin
        if (st.emit_last) begin
          emit_k_r <= '0;
          count_r  <= '0;
        end else begin
          emit_k_r <= emit_k_r + IDX_W'(1);
        end
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.range_load) begin
      lo_r <= stack_q_r[STK_W-1:IDX_W];
      hi_r <= stack_q_r[IDX_W-1:0];
    end
    if (cmd.step) begin
      swap_addr_r <= high_r;
      swap_data_r <= q_a_r;
    end
    if (cmd.emit) last_r <= st.emit_last;
  end

  always_comb begin
    st.cnt_zero    = (count_r == '0);
    st.cnt_ge2     = (count_r >= CNT_W'(2));
    st.stack_empty = (depth_r == '0);
    st.scan_done   = (low_r >= high_r);
    st.swap        = swap;
    st.right_ok    = ({1'b0, low_r} + CNT_W'(1)) < {1'b0, hi_r};
    st.left_ok     = ({1'b0, lo_r} + CNT_W'(1)) < {1'b0, low_r};
    st.emit_last   = ({1'b0, emit_k_r} + CNT_W'(1)) == count_r;
  end

  assign out_valid         = out_valid_r;
  assign out_res.value_res = q_a_r;
  assign out_res.last_res  = last_r;

endmodule

>>> design/iterative_quicksort_engine.sv
// Top level of the iterative quicksort engine: controller plus datapath.
//
// A request carries one signed 32-bit value and a last flag. A request is
// taken at a rising edge where start is high and busy is low; requests that
// are not marked last are stored and keep busy low, and values beyond the
// 64-entry capacity are dropped. A request marked last raises busy and
// starts the sort of everything held. The sort is a quicksort with the
// first element of each range as pivot; pending ranges sit on a range
// stack. Each scan step is a registered read of both scan ends from the
// element memory, then a compare, and a swap adds a write state because the
// memory has a single write port; each partitioned range also passes
// through pop, range load, the scan check that ends it and two push slots,
// and the sort adds a start state and a final pop that finds the stack
// empty. Expect on the order of n*log2(n) compares for random data and up
// to n*n/2 for already sorted input. Results then stream out one per cycle,
// n in a row, with last_res on the final one; out_valid is high for exactly
// one cycle per result and the receiver cannot stall the stream, so it must
// take every strobe. busy drops with the final read; the final result shows
// in the cycle after, when a new request may already be taken.
module iterative_quicksort_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  iqs_pkg::in_req_t  in_req,
  output logic              out_valid,
  output iqs_pkg::out_res_t out_res
);

`include "iterative_quicksort_engine_macros.svh"

  iqs_pkg::iqs_cmd_t  cmd;
  iqs_pkg::iqs_stat_t st;

  // Sequence loading, partitioning and the output burst.
  iqs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_req.last),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Hold the element store, range stack and scan pointers.
  iqs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // A result only follows a cycle in which the engine was busy.
  `IQS_ASSERT_IMPL(a_out_after_busy, clk, rst_n, out_valid, $past(busy))
  // A plain load request never starts the sort.
  `IQS_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, start && !busy && !in_req.last, !busy)
  // A last request always starts the sort.
  `IQS_ASSERT_NEXT(a_last_goes_busy, clk, rst_n, start && !busy && in_req.last, busy)
  // The burst ends on the result marked last.
  `IQS_ASSERT_NEXT(a_burst_ends, clk, rst_n, out_valid && out_res.last_res, !out_valid)

endmodule
